@@ design/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GCM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gcm assertion failed");

// next-cycle implication
`define GCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gcm assertion failed");

`endif

@@ design/gcm_pkg.sv @@
package gcm_pkg;

  localparam int MAX_DENOMS_DEF   = 7;
  localparam int AMOUNT_WIDTH_DEF = 32;

  localparam int DENOM_W   = 16;
  localparam int FIELD_W   = 32;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DENOM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_BASE  = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_START,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              sort_we;
    logic              div_start;
    logic              div_step;
    logic              out_load;
    logic              last;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] n_last;
  } status_t;

endpackage

@@ design/greedy_change_maker.sv @@
// channel   ports                                   direction
// in        in_valid, in_stall, in_amount           word in, one amount
// out       out_valid, out_stall, out_slot, ...     word out, one per denomination
// cfg       cfg_we, cfg_index, cfg_wdata            register write, no read-back
//
// per amount: accept in ST_IDLE, ST_SORT ranking the slots, then for each of the n
// denominations ST_START loading the divider, ST_DIV stepping AMOUNT_WIDTH bits
// (capped at 32), ST_DONE loading the result, ST_OUT holding the word until taken.
// the divider is bit-serial and restoring; one amount is in flight at a time.
// reset is synchronous, active low; denominations and count reset to 1.
// out_stall holds the result word and the divider; in_stall is high while busy.
module greedy_change_maker #(
  parameter int MAX_DENOMS   = gcm_pkg::MAX_DENOMS_DEF,
  parameter int AMOUNT_WIDTH = gcm_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcm_pkg::DENOM_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gcm_pkg::FIELD_W-1:0]   in_amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gcm_pkg::SLOT_W-1:0]    out_slot,
  output logic [gcm_pkg::DENOM_W-1:0]   out_denomination,
  output logic [gcm_pkg::FIELD_W-1:0]   out_note_count,
  output logic [gcm_pkg::FIELD_W-1:0]   out_amount_left,
  output logic                          out_last
);

  gcm_pkg::cmd_t    cmd;
  gcm_pkg::status_t status;

  gcm_ctrl #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gcm_datapath #(
    .MAX_DENOMS   (MAX_DENOMS),
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_amount        (in_amount),
    .cmd              (cmd),
    .status           (status),
    .out_slot         (out_slot),
    .out_denomination (out_denomination),
    .out_note_count   (out_note_count),
    .out_amount_left  (out_amount_left),
    .out_last         (out_last)
  );

endmodule

@@ design/gcm_datapath.sv @@
module gcm_datapath #(
  parameter int MAX_DENOMS   = gcm_pkg::MAX_DENOMS_DEF,
  parameter int AMOUNT_WIDTH = gcm_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gcm_pkg::DENOM_W-1:0]         cfg_wdata,
  input  logic [gcm_pkg::FIELD_W-1:0]         in_amount,
  input  gcm_pkg::cmd_t                       cmd,
  output gcm_pkg::status_t                    status,
  output logic [gcm_pkg::SLOT_W-1:0]          out_slot,
  output logic [gcm_pkg::DENOM_W-1:0]         out_denomination,
  output logic [gcm_pkg::FIELD_W-1:0]         out_note_count,
  output logic [gcm_pkg::FIELD_W-1:0]         out_amount_left,
  output logic                                out_last
);

  localparam int AW = (AMOUNT_WIDTH < gcm_pkg::FIELD_W) ? AMOUNT_WIDTH : gcm_pkg::FIELD_W;
  localparam int IW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int DW = gcm_pkg::DENOM_W;

  logic [gcm_pkg::COUNT_W-1:0] denom_count_r;
  logic [DW-1:0]               denom_r [MAX_DENOMS];
  logic [IW-1:0]               order_r [MAX_DENOMS];
  logic [gcm_pkg::COUNT_W-1:0] used_n;
  logic [IW-1:0]               sort_idx;
  logic [DW-1:0]               sort_val;
  logic [gcm_pkg::COUNT_W-1:0] rank;
  logic [IW-1:0]               cur_slot;

  logic [AW-1:0]               rest_r;
  logic [AW-1:0]               quo_r;
  logic [DW-1:0]               rem_r;
  logic [DW-1:0]               dvsr_r;
  logic [IW-1:0]               slot_r;
  logic [DW:0]                 trial;
  logic [DW:0]                 diff;
  logic                        fits;
  logic                        dvsr_zero;

  logic [gcm_pkg::SLOT_W-1:0]  out_slot_r;
  logic [DW-1:0]               out_denom_r;
  logic [gcm_pkg::FIELD_W-1:0] out_cnt_r;
  logic [gcm_pkg::FIELD_W-1:0] out_left_r;
  logic                        out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      denom_count_r <= gcm_pkg::COUNT_W'(1);
      for (int i = 0; i < MAX_DENOMS; i++) begin
        denom_r[i] <= DW'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index == gcm_pkg::REG_DENOM_COUNT) begin
        denom_count_r <= cfg_wdata[gcm_pkg::COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_DENOMS; i++) begin
        if (cfg_index == gcm_pkg::CFG_IDX_W'(int'(gcm_pkg::REG_DENOM_BASE) + i)) begin
          denom_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // zero count means one slot, above the slot count saturates
  always_comb begin
    if (denom_count_r == '0) begin
      used_n = gcm_pkg::COUNT_W'(1);
    end else if (denom_count_r > gcm_pkg::COUNT_W'(MAX_DENOMS)) begin
      used_n = gcm_pkg::COUNT_W'(MAX_DENOMS);
    end else begin
      used_n = denom_count_r;
    end
  end

  assign status.n_last = used_n - gcm_pkg::COUNT_W'(1);

  // stable descending rank of one slot against all slots in use
  assign sort_idx = cmd.idx[IW-1:0];
  assign sort_val = denom_r[sort_idx];

  always_comb begin
    rank = '0;
    for (int j = 0; j < MAX_DENOMS; j++) begin
      if ((gcm_pkg::COUNT_W'(j) < used_n) &&
          ((denom_r[j] > sort_val) || ((denom_r[j] == sort_val) && (IW'(j) < sort_idx)))) begin
        rank = rank + gcm_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_we) begin
      order_r[rank[IW-1:0]] <= sort_idx;
    end
  end

  assign cur_slot = order_r[cmd.idx[IW-1:0]];

  // restoring divider, one quotient bit per cycle
  assign trial     = {rem_r, quo_r[AW-1]};
  assign diff      = trial - {1'b0, dvsr_r};
  assign fits      = (trial >= {1'b0, dvsr_r});
  assign dvsr_zero = (dvsr_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r <= in_amount[AW-1:0];
    end else if (cmd.out_load && !dvsr_zero) begin
      rest_r <= AW'(rem_r);
    end
    if (cmd.div_start) begin
      quo_r  <= rest_r;
      rem_r  <= '0;
      dvsr_r <= denom_r[cur_slot];
      slot_r <= cur_slot;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[AW-2:0], fits};
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot_r  <= gcm_pkg::SLOT_W'(slot_r);
      out_denom_r <= dvsr_r;
      out_cnt_r   <= dvsr_zero ? '0 : gcm_pkg::FIELD_W'(quo_r);
      out_left_r  <= dvsr_zero ? gcm_pkg::FIELD_W'(rest_r) : gcm_pkg::FIELD_W'(rem_r);
      out_last_r  <= cmd.last;
    end
  end

  assign out_slot         = out_slot_r;
  assign out_denomination = out_denom_r;
  assign out_note_count   = out_cnt_r;
  assign out_amount_left  = out_left_r;
  assign out_last         = out_last_r;

endmodule

@@ design/gcm_ctrl.sv @@
`include "assert_macros.svh"

module gcm_ctrl #(
  parameter int AMOUNT_WIDTH = gcm_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  gcm_pkg::status_t status,
  output gcm_pkg::cmd_t    cmd
);

  localparam int AW  = (AMOUNT_WIDTH < gcm_pkg::FIELD_W) ? AMOUNT_WIDTH : gcm_pkg::FIELD_W;
  localparam int SCW = $clog2(AW);

  gcm_pkg::state_t             state_r, state_nxt;
  logic [gcm_pkg::SLOT_W-1:0]  idx_r, idx_nxt;
  logic [SCW-1:0]              step_r, step_nxt;
  logic                        at_last;
  logic                        in_acc;
  logic                        out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gcm_pkg::ST_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

  assign at_last   = (idx_r == status.n_last);
  assign in_stall  = (state_r != gcm_pkg::ST_IDLE) || !rst_n;
  assign out_valid = (state_r == gcm_pkg::ST_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.last      = at_last;
    case (state_r)
      gcm_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = gcm_pkg::ST_SORT;
        end
      end
      gcm_pkg::ST_SORT: begin
        // one slot ranked per cycle
        cmd.sort_we = 1'b1;
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = gcm_pkg::ST_START;
        end else begin
          idx_nxt = idx_r + gcm_pkg::SLOT_W'(1);
        end
      end
      gcm_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        step_nxt      = SCW'(AW - 1);
        state_nxt     = gcm_pkg::ST_DIV;
      end
      gcm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = gcm_pkg::ST_DONE;
        end else begin
          step_nxt = step_r - SCW'(1);
        end
      end
      gcm_pkg::ST_DONE: begin
        cmd.out_load = 1'b1;
        state_nxt    = gcm_pkg::ST_OUT;
      end
      gcm_pkg::ST_OUT: begin
        if (!out_stall) begin
          if (at_last) begin
            state_nxt = gcm_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + gcm_pkg::SLOT_W'(1);
            state_nxt = gcm_pkg::ST_START;
          end
        end
      end
      default: begin
        state_nxt = gcm_pkg::ST_IDLE;
      end
    endcase
  end

  `GCM_ASSERT_NEXT(a_accept_sorts, clk, rst_n, in_acc, state_r == gcm_pkg::ST_SORT)
  `GCM_ASSERT_NEXT(a_div_ends, clk, rst_n, (state_r == gcm_pkg::ST_DIV) && (step_r == '0), state_r == gcm_pkg::ST_DONE)
  `GCM_ASSERT_NEXT(a_last_word_idles, clk, rst_n, out_acc && at_last, state_r == gcm_pkg::ST_IDLE)
  `GCM_ASSERT_IMPLY(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.sort_we, cmd.div_start, cmd.div_step, cmd.out_load}))

endmodule
